### rtl/core/gnpo_pkg.sv
// Shared types and constants for the greedy nearest point order unit.
// No dependencies; gnpo_dist_pipe and the top-level unit import this package.
package gnpo_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 12;
  localparam int COORD_OUT  = 12;   // width of the coordinate fields on the channels
  localparam int TAG_W      = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int D2_W       = SQ_W + 1;
  localparam int ROOT_W     = COORD_BITS + 1;
  localparam int REM_W      = ROOT_W + 2;
  localparam int WORD_W     = 2 * COORD_BITS + TAG_W;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TAG_W-1:0]      tag_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ROOT_W-1:0]     root_t;

  // One stored point plus its place in the store.
  typedef struct packed {
    idx_t   idx;
    coord_t px;
    coord_t py;
    tag_t   tag;
  } cand_t;

  typedef enum logic [3:0] {
    S_IN,
    S_OINIT,
    S_OCAP,
    S_SCAN,
    S_DRAIN,
    S_SW1,
    S_SW2,
    S_ERD,
    S_ELD,
    S_EHOLD
  } state_t;

endpackage

### rtl/core/gnpo_if.sv
// Valid/ready channel interfaces for point input and ordered point output.
// No dependencies; the field widths are written out as literals.
interface gnpo_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] px;
  logic [11:0] py;
  logic [31:0] tag;
  logic        last_in;

  modport source (output valid, px, py, tag, last_in, input ready);
  modport sink   (input valid, px, py, tag, last_in, output ready);
endinterface

interface gnpo_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] ox;
  logic [11:0] oy;
  logic [31:0] otag;
  logic        last_out;
  logic        overflow;

  modport source (output valid, ox, oy, otag, last_out, overflow, input ready);
  modport sink   (input valid, ox, oy, otag, last_out, overflow, output ready);
endinterface

### rtl/core/gnpo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gnpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/gnpo_dist_pipe.sv
// Distance pipeline: abs difference, squares, sum, then one root bit per stage.
// Depends on gnpo_pkg.
module gnpo_dist_pipe
  import gnpo_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  cand_t  in_cand,
  input  coord_t cur_x,
  input  coord_t cur_y,
  output logic   out_valid,
  output cand_t  out_cand,
  output root_t  out_dist,
  output logic   busy
);

  logic            v1, v2, v3;
  cand_t           c1, c2, c3;
  coord_t          dx1, dy1;
  logic [SQ_W-1:0] sqx2, sqy2;
  logic [D2_W-1:0] d2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    c1   <= in_cand;
    dx1  <= (in_cand.px > cur_x) ? in_cand.px - cur_x : cur_x - in_cand.px;
    dy1  <= (in_cand.py > cur_y) ? in_cand.py - cur_y : cur_y - in_cand.py;
    c2   <= c1;
    sqx2 <= dx1 * dx1;
    sqy2 <= dy1 * dy1;
    c3   <= c2;
    d2_3 <= {1'b0, sqx2} + {1'b0, sqy2};
  end

  // Root stages: each takes the next bit pair of the radicand.
  logic                  sv   [0:ROOT_W-1];
  cand_t                 sc   [0:ROOT_W-1];
  logic [REM_W-1:0]      srem [0:ROOT_W-1];
  root_t                 sroot[0:ROOT_W-1];
  logic [2*ROOT_W-1:0]   sval [0:ROOT_W-1];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    logic                v_in;
    cand_t               c_in;
    logic [REM_W-1:0]    rem_in, rem_sh, trial;
    root_t               root_in;
    logic [2*ROOT_W-1:0] val_in;

    if (g == 0) begin : g_first
      assign v_in    = v3;
      assign c_in    = c3;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = {1'b0, d2_3};
    end else begin : g_next
      assign v_in    = sv[g-1];
      assign c_in    = sc[g-1];
      assign rem_in  = srem[g-1];
      assign root_in = sroot[g-1];
      assign val_in  = sval[g-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], val_in[2*ROOT_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g] <= 1'b0;
      end else begin
        sv[g] <= v_in;
      end
      sc[g]   <= c_in;
      sval[g] <= {val_in[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        srem[g]  <= rem_sh - trial;
        sroot[g] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        srem[g]  <= rem_sh;
        sroot[g] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  logic [ROOT_W-1:0] vbits;
  for (genvar g = 0; g < ROOT_W; g++) begin : g_vb
    assign vbits[g] = sv[g];
  end

  assign out_valid = sv[ROOT_W-1];
  assign out_cand  = sc[ROOT_W-1];
  assign out_dist  = sroot[ROOT_W-1];
  assign busy      = v1 | v2 | v3 | (|vbits);

endmodule

### rtl/core/greedy_nearest_point_order_unit.sv
// Greedy nearest point order unit: loads up to MAX_POINTS points per set, orders them
// greedily by integer Euclidean distance, then emits them. Loading takes one beat a cycle.
// Ordering: one store read a cycle feeds a 16-stage distance pipeline; the pipeline then
// drains and a swap moves the nearest point into the next tour position, for each position.
// Emission reads each point from the store, loads the output register, then awaits the handshake.
// Reset (rst, synchronous) clears control state; store contents stay undefined.
module greedy_nearest_point_order_unit
  import gnpo_pkg::*;
(
  input logic clk,
  input logic rst,
  gnpo_in_if.sink    in_ch,
  gnpo_out_if.source out_ch
);

  state_t state, state_next;

  cnt_t   count;      // points held
  logic   dropped;    // a point of this set hit capacity
  cnt_t   n;          // size of the set being ordered or emitted
  logic   ovf_set;
  cnt_t   i;          // tour position being extended
  cnt_t   j;          // next candidate to read
  cnt_t   k;          // next point to emit

  coord_t cur_x, cur_y;
  cand_t  best, first;
  root_t  best_d;

  logic   issue_v;
  idx_t   issue_idx;

  // Store port
  logic                ram_we;
  idx_t                ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  // Distance pipeline
  logic  pipe_out_v, pipe_busy;
  cand_t pipe_in, pipe_out;
  root_t pipe_dist;

  // Output register
  logic   ovalid;
  coord_t ox_r, oy_r;
  tag_t   otag_r;
  logic   olast_r, oovf_r;

  logic in_beat, out_beat, room;
  cnt_t n_new;

  assign in_beat  = in_ch.valid & in_ch.ready;
  assign out_beat = out_ch.valid & out_ch.ready;
  assign room     = (count < cnt_t'(MAX_POINTS));
  assign n_new    = room ? count + cnt_t'(1) : count;

  gnpo_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pipe_in = '{idx: issue_idx,
                     px:  ram_rdata[WORD_W-1 -: COORD_BITS],
                     py:  ram_rdata[TAG_W+COORD_BITS-1 -: COORD_BITS],
                     tag: ram_rdata[TAG_W-1:0]};

  gnpo_dist_pipe u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue_v),
    .in_cand   (pipe_in),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .out_valid (pipe_out_v),
    .out_cand  (pipe_out),
    .out_dist  (pipe_dist),
    .busy      (pipe_busy)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IN: begin
        if (in_beat && in_ch.last_in) begin
          state_next = (n_new < cnt_t'(2)) ? S_ERD : S_OINIT;
        end
      end
      S_OINIT: state_next = S_OCAP;
      S_OCAP:  state_next = S_SCAN;
      S_SCAN: begin
        if (j == n - cnt_t'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!issue_v && !pipe_busy) begin
          state_next = S_SW1;
        end
      end
      S_SW1: state_next = S_SW2;
      S_SW2: begin
        state_next = (i + cnt_t'(2) == n) ? S_ERD : S_SCAN;
      end
      S_ERD: begin
        if (!ovalid) begin
          state_next = S_ELD;
        end
      end
      S_ELD: begin
        state_next = (k + cnt_t'(1) == n) ? S_IN : S_EHOLD;
      end
      S_EHOLD: begin
        if (out_beat) begin
          state_next = S_ERD;
        end
      end
      default: state_next = S_IN;
    endcase
  end

  // Store port and handshake outputs
  always_comb begin
    in_ch.ready = (state == S_IN);
    ram_we      = 1'b0;
    ram_waddr   = count[IDX_W-1:0];
    ram_wdata   = {in_ch.px[COORD_BITS-1:0], in_ch.py[COORD_BITS-1:0], in_ch.tag};
    ram_raddr   = '0;
    case (state)
      S_IN: begin
        ram_we = in_beat & room;
      end
      S_SCAN: begin
        ram_raddr = j[IDX_W-1:0];
      end
      S_SW1: begin
        // Move the nearest point into the next tour position.
        ram_we    = 1'b1;
        ram_waddr = i[IDX_W-1:0] + idx_t'(1);
        ram_wdata = {best.px, best.py, best.tag};
      end
      S_SW2: begin
        // Put the displaced point where the nearest one was.
        ram_we    = 1'b1;
        ram_waddr = best.idx;
        ram_wdata = {first.px, first.py, first.tag};
      end
      S_ERD: begin
        ram_raddr = k[IDX_W-1:0];
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IN;
      count   <= '0;
      dropped <= 1'b0;
      issue_v <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      issue_v <= (state == S_SCAN);
      if (state == S_IN && in_beat) begin
        if (room) begin
          count <= count + cnt_t'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (state == S_ELD) begin
        ovalid <= 1'b1;
        if (k + cnt_t'(1) == n) begin
          // Set done: clear for the next one while the last beat may still wait.
          count   <= '0;
          dropped <= 1'b0;
        end
      end else if (out_beat) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    issue_idx <= j[IDX_W-1:0];
    case (state)
      S_IN: begin
        if (in_beat && in_ch.last_in) begin
          n       <= n_new;
          ovf_set <= dropped | ~room;
          i       <= '0;
          k       <= '0;
        end
      end
      S_OCAP: begin
        cur_x <= ram_rdata[WORD_W-1 -: COORD_BITS];
        cur_y <= ram_rdata[TAG_W+COORD_BITS-1 -: COORD_BITS];
        j     <= cnt_t'(1);
      end
      S_SCAN: begin
        j <= j + cnt_t'(1);
      end
      S_SW2: begin
        // Nearest point becomes the new tour end.
        cur_x <= best.px;
        cur_y <= best.py;
        i     <= i + cnt_t'(1);
        j     <= i + cnt_t'(2);
      end
      S_ELD: begin
        ox_r    <= ram_rdata[WORD_W-1 -: COORD_BITS];
        oy_r    <= ram_rdata[TAG_W+COORD_BITS-1 -: COORD_BITS];
        otag_r  <= ram_rdata[TAG_W-1:0];
        olast_r <= (k + cnt_t'(1) == n);
        oovf_r  <= ovf_set;
        k       <= k + cnt_t'(1);
      end
      default: begin
      end
    endcase
    // Track the nearest candidate; the first one in scan order seeds it, ties keep the earlier.
    if (pipe_out_v) begin
      if (pipe_out.idx == i[IDX_W-1:0] + idx_t'(1)) begin
        first  <= pipe_out;
        best   <= pipe_out;
        best_d <= pipe_dist;
      end else if (pipe_dist < best_d) begin
        best   <= pipe_out;
        best_d <= pipe_dist;
      end
    end
  end

  assign out_ch.valid    = ovalid;
  assign out_ch.ox       = COORD_OUT'(ox_r);
  assign out_ch.oy       = COORD_OUT'(oy_r);
  assign out_ch.otag     = otag_r;
  assign out_ch.last_out = olast_r;
  assign out_ch.overflow = oovf_r;

endmodule
